### hw/rtl/mqdr_pkg.sv
// Shared types, sizes, codes and helpers of the multi-queue drain and redistribute bank.
`default_nettype none

package mqdr_pkg;

   // Bank geometry.
   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 16;

   // Derived widths.
   localparam int QW    = $clog2(NUM_QUEUES);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   // Port widths fixed by the interface.
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 3;
   localparam int CID_W   = 16;
   localparam int STAT_W  = 2;
   localparam int CFG_W   = 4;

   // Width used to compare queue indexes against the active count.
   localparam int CMP_W = 8;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ENQ   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SERVE = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

   // Per-queue descriptor.
   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [CNT_W-1:0] count;
   } desc_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DESC,
      SEQ_POP,
      SEQ_SCAN,
      SEQ_MOVE,
      SEQ_WB
   } state_type;

   // Advance a slot pointer with wrap at the queue depth.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Flat entry store address of one slot of one queue.
   function automatic logic [AW-1:0] entry_addr(input logic [QW-1:0] q,
                                                input logic [PTR_W-1:0] p);
      return AW'(AW'(q) * AW'(QUEUE_DEPTH)) + AW'(p);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/multi_queue_drain_redistribute_top.sv
// Top level: operation sequencer around the descriptor and entry stores.
//
//   Channel   Ports                                        Transfer
//   request   start, busy, req_func, req_queue_index,      start && !busy
//             req_client_id
//   response  rsp_valid, rsp_status, rsp_served_id,        rsp_valid (one cycle)
//             rsp_queue_empty
//   config    csr_wr_en, csr_wr_data                       csr_wr_en
//
// Enqueue, an invalid index, an undefined code, a refused close and a close or serve of
// an empty queue end in the descriptor state; other serves add an entry read state.
// Any other close visits the active queues in passes: a scan and a move state for each
// other active queue, the move waiting on its descriptor read, and a scan state for
// the closed queue itself. The result is registered and shows in the cycle after the
// last state of work, and busy is high from the transfer until then.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none

module multi_queue_drain_redistribute_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mqdr_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [mqdr_pkg::IDX_W-1:0]      req_queue_index,
   input  wire logic [mqdr_pkg::CID_W-1:0]      req_client_id,
   output logic                                 rsp_valid,
   output logic      [mqdr_pkg::STAT_W-1:0]     rsp_status,
   output logic      [mqdr_pkg::CID_W-1:0]      rsp_served_id,
   output logic                                 rsp_queue_empty,
   input  wire logic                            csr_wr_en,
   input  wire logic [mqdr_pkg::CFG_W-1:0]      csr_wr_data
);
   import mqdr_pkg::*;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       active_ff;
   logic [CMP_W-1:0]       live;

   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [QW-1:0]          q_ff, q_in;
   logic                   idx_ok_ff, idx_ok_in;
   logic [ID_WIDTH-1:0]    id_ff, id_in;
   desc_type               qdesc_ff, qdesc_in;
   logic [QW-1:0]          scan_ff, scan_in;
   logic                   moved_ff, moved_in;
   logic [STAT_W-1:0]      stat_ff, stat_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [CID_W-1:0]       rsp_served_id_ff, rsp_served_id_in;
   logic                   rsp_queue_empty_ff, rsp_queue_empty_in;

   logic                   desc_rd_en, desc_wr_en;
   logic [QW-1:0]          desc_rd_addr, desc_wr_addr;
   desc_type               desc_rd_data, desc_wr_data;

   logic                   entry_rd_en, entry_wr_en;
   logic [AW-1:0]          entry_rd_addr, entry_wr_addr;
   logic [ID_WIDTH-1:0]    entry_rd_data, entry_wr_data;

   // Storage.
   mqdr_desc_ram u_desc (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (desc_rd_en),
      .rd_addr (desc_rd_addr),
      .rd_data (desc_rd_data),
      .wr_en   (desc_wr_en),
      .wr_addr (desc_wr_addr),
      .wr_data (desc_wr_data)
   );

   mqdr_entry_ram u_entry (
      .clock   (clock),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data)
   );

   // Active queue count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // Queues in use, limited to the bank size.
   assign live = (CMP_W'(active_ff) > CMP_W'(NUM_QUEUES)) ? CMP_W'(NUM_QUEUES)
                                                          : CMP_W'(active_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operation context and result payload.
   always_ff @(posedge clock) begin
      func_ff            <= func_in;
      q_ff               <= q_in;
      idx_ok_ff          <= idx_ok_in;
      id_ff              <= id_in;
      qdesc_ff           <= qdesc_in;
      scan_ff            <= scan_in;
      moved_ff           <= moved_in;
      stat_ff            <= stat_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_served_id_ff   <= rsp_served_id_in;
      rsp_queue_empty_ff <= rsp_queue_empty_in;
   end

   // Sequencer: next state, memory accesses and result.
   always_comb begin
      desc_type               d;
      logic                   moved_now;
      logic [CNT_W-1:0]       cnt_now;
      logic                   last;

      d         = desc_rd_data;
      moved_now = moved_ff;
      cnt_now   = qdesc_ff.count;
      last      = (CMP_W'(scan_ff) == (live - CMP_W'(1)));

      state_in           = state_ff;
      func_in            = func_ff;
      q_in               = q_ff;
      idx_ok_in          = idx_ok_ff;
      id_in              = id_ff;
      qdesc_in           = qdesc_ff;
      scan_in            = scan_ff;
      moved_in           = moved_ff;
      stat_in            = stat_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_served_id_in   = rsp_served_id_ff;
      rsp_queue_empty_in = rsp_queue_empty_ff;

      desc_rd_en    = 1'b0;
      desc_rd_addr  = q_ff;
      desc_wr_en    = 1'b0;
      desc_wr_addr  = q_ff;
      desc_wr_data  = qdesc_ff;
      entry_rd_en   = 1'b0;
      entry_rd_addr = entry_addr(q_ff, qdesc_ff.head);
      entry_wr_en   = 1'b0;
      entry_wr_addr = entry_addr(q_ff, d.tail);
      entry_wr_data = id_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            // Take the request and fetch the addressed descriptor.
            if (start) begin
               func_in      = req_func;
               q_in         = QW'(req_queue_index);
               idx_ok_in    = (CMP_W'(req_queue_index) < live);
               id_in        = ID_WIDTH'(req_client_id);
               desc_rd_en   = 1'b1;
               desc_rd_addr = QW'(req_queue_index);
               state_in     = SEQ_DESC;
            end
         end

         SEQ_DESC: begin
            rsp_served_id_in = '0;
            if (!idx_ok_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STAT_INVALID;
               rsp_queue_empty_in = 1'b0;
               state_in           = SEQ_IDLE;
            end else begin
               unique case (func_ff)
                  FUNC_ENQ: begin
                     rsp_valid_in       = 1'b1;
                     rsp_queue_empty_in = 1'b0;
                     state_in           = SEQ_IDLE;
                     if (d.count == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        entry_wr_en        = 1'b1;
                        entry_wr_addr      = entry_addr(q_ff, d.tail);
                        entry_wr_data      = id_ff;
                        desc_wr_en         = 1'b1;
                        desc_wr_addr       = q_ff;
                        desc_wr_data.head  = d.head;
                        desc_wr_data.tail  = ptr_inc(d.tail);
                        desc_wr_data.count = d.count + 1'b1;
                        rsp_status_in      = STAT_OK;
                     end
                  end

                  FUNC_SERVE: begin
                     if (d.count == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_status_in      = STAT_EMPTY;
                        rsp_queue_empty_in = 1'b1;
                        state_in           = SEQ_IDLE;
                     end else begin
                        // Read the head entry and retire it in the descriptor.
                        entry_rd_en    = 1'b1;
                        entry_rd_addr  = entry_addr(q_ff, d.head);
                        qdesc_in.head  = ptr_inc(d.head);
                        qdesc_in.tail  = d.tail;
                        qdesc_in.count = d.count - 1'b1;
                        desc_wr_en     = 1'b1;
                        desc_wr_addr   = q_ff;
                        desc_wr_data   = qdesc_in;
                        state_in       = SEQ_POP;
                     end
                  end

                  FUNC_CLOSE: begin
                     if (live < CMP_W'(2)) begin
                        rsp_valid_in       = 1'b1;
                        rsp_status_in      = STAT_INVALID;
                        rsp_queue_empty_in = (d.count == '0);
                        state_in           = SEQ_IDLE;
                     end else if (d.count == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_status_in      = STAT_OK;
                        rsp_queue_empty_in = 1'b1;
                        state_in           = SEQ_IDLE;
                     end else begin
                        // Keep the closed queue's descriptor here during the drain.
                        qdesc_in = d;
                        scan_in  = '0;
                        moved_in = 1'b0;
                        state_in = SEQ_SCAN;
                     end
                  end

                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_status_in      = STAT_INVALID;
                     rsp_queue_empty_in = (d.count == '0);
                     state_in           = SEQ_IDLE;
                  end
               endcase
            end
         end

         SEQ_POP: begin
            // Head entry data has arrived.
            rsp_valid_in       = 1'b1;
            rsp_status_in      = STAT_OK;
            rsp_served_id_in   = CID_W'(entry_rd_data);
            rsp_queue_empty_in = (qdesc_ff.count == '0);
            state_in           = SEQ_IDLE;
         end

         SEQ_SCAN: begin
            if (scan_ff == q_ff) begin
               // The closed queue is not a target; step to the next queue or pass, or stop.
               if (last) begin
                  if (!moved_ff) begin
                     stat_in  = STAT_FULL;
                     state_in = SEQ_WB;
                  end else begin
                     scan_in  = '0;
                     moved_in = 1'b0;
                  end
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end else begin
               // Fetch the target descriptor and the closed queue's head entry.
               desc_rd_en    = 1'b1;
               desc_rd_addr  = scan_ff;
               entry_rd_en   = 1'b1;
               entry_rd_addr = entry_addr(q_ff, qdesc_ff.head);
               state_in      = SEQ_MOVE;
            end
         end

         SEQ_MOVE: begin
            // Append the head entry to the target unless it is full.
            if (d.count != CNT_W'(QUEUE_DEPTH)) begin
               entry_wr_en        = 1'b1;
               entry_wr_addr      = entry_addr(scan_ff, d.tail);
               entry_wr_data      = entry_rd_data;
               desc_wr_en         = 1'b1;
               desc_wr_addr       = scan_ff;
               desc_wr_data.head  = d.head;
               desc_wr_data.tail  = ptr_inc(d.tail);
               desc_wr_data.count = d.count + 1'b1;
               qdesc_in.head      = ptr_inc(qdesc_ff.head);
               qdesc_in.count     = qdesc_ff.count - 1'b1;
               cnt_now            = qdesc_ff.count - 1'b1;
               moved_now          = 1'b1;
            end
            if (cnt_now == '0) begin
               stat_in  = STAT_OK;
               state_in = SEQ_WB;
            end else if (last) begin
               if (!moved_now) begin
                  stat_in  = STAT_FULL;
                  state_in = SEQ_WB;
               end else begin
                  scan_in  = '0;
                  moved_in = 1'b0;
                  state_in = SEQ_SCAN;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               moved_in = moved_now;
               state_in = SEQ_SCAN;
            end
         end

         SEQ_WB: begin
            // Write back the closed queue's descriptor and report.
            desc_wr_en         = 1'b1;
            desc_wr_addr       = q_ff;
            desc_wr_data       = qdesc_ff;
            rsp_valid_in       = 1'b1;
            rsp_status_in      = stat_ff;
            rsp_served_id_in   = '0;
            rsp_queue_empty_in = (qdesc_ff.count == '0);
            state_in           = SEQ_IDLE;
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != SEQ_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_served_id   = rsp_served_id_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;

endmodule

`default_nettype wire

### hw/rtl/mqdr_entry_ram.sv
// Entry store: one id per slot of every queue, one write and one read port.
`default_nettype none

module mqdr_entry_ram (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [mqdr_pkg::AW-1:0]        rd_addr,
   output logic      [mqdr_pkg::ID_WIDTH-1:0]  rd_data,
   input  wire logic                           wr_en,
   input  wire logic [mqdr_pkg::AW-1:0]        wr_addr,
   input  wire logic [mqdr_pkg::ID_WIDTH-1:0]  wr_data
);
   import mqdr_pkg::*;

   logic [ID_WIDTH-1:0] store_ff [NUM_QUEUES * QUEUE_DEPTH];
   logic [ID_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/mqdr_desc_ram.sv
// Descriptor store: head, tail and count per queue, with valid bits so reset reads as zero.
`default_nettype none

module mqdr_desc_ram (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [mqdr_pkg::QW-1:0]  rd_addr,
   output mqdr_pkg::desc_type            rd_data,
   input  wire logic                     wr_en,
   input  wire logic [mqdr_pkg::QW-1:0]  wr_addr,
   input  wire mqdr_pkg::desc_type       wr_data
);
   import mqdr_pkg::*;

   desc_type                store_ff [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]   valid_ff;
   desc_type                rd_data_ff;
   logic                    rd_valid_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Valid bits: cleared by reset, set on the first write of an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read port; an entry never written reads as all zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### hw/rtl/mqdr_checker.sv
// Port-level checks of the queue bank, bound to the top level.
`default_nettype none

module mqdr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic [mqdr_pkg::STAT_W-1:0]     rsp_status,
   input wire logic [mqdr_pkg::CID_W-1:0]      rsp_served_id,
   input wire logic                            rsp_queue_empty
);
   import mqdr_pkg::*;

   // A request transfer always starts a busy period.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   // A result is shown only once the operation has finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // Results never come in two adjacent cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A failed operation returns no id; only a successful serve returns one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_served_id == '0))
      else $error("served id nonzero on a failed operation");

   // A serve that found nothing leaves the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_EMPTY)) |-> rsp_queue_empty)
      else $error("empty status without empty flag");

endmodule

bind multi_queue_drain_redistribute_top mqdr_checker u_mqdr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_served_id   (rsp_served_id),
   .rsp_queue_empty (rsp_queue_empty)
);

`default_nettype wire

### bench/mqdr_outcome_checker.sv
// Checker for the queue bank: follows requests, results and register writes, predicts results.
module mqdr_outcome_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [mqdr_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [mqdr_pkg::IDX_W-1:0]    req_queue_index,
   input  wire logic [mqdr_pkg::CID_W-1:0]    req_client_id,
   input  wire logic                          rsp_valid,
   input  wire logic [mqdr_pkg::STAT_W-1:0]   rsp_status,
   input  wire logic [mqdr_pkg::CID_W-1:0]    rsp_served_id,
   input  wire logic                          rsp_queue_empty,
   input  wire logic                          csr_wr_en,
   input  wire logic [mqdr_pkg::CFG_W-1:0]    csr_wr_data,
   output int                                 mismatch_count,
   output int                                 open_count,
   output int                                 checked_count,
   output int                                 stuck_close_count
);
   import mqdr_pkg::*;

   // One predicted result.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CID_W-1:0]  served;
      logic              empty;
   } outcome_type;

   // Mirror of the bank: slots, pointers and fill level per queue.
   logic [ID_WIDTH-1:0] slot_mem [NUM_QUEUES][QUEUE_DEPTH];
   logic [PTR_W-1:0]    head_slot [NUM_QUEUES];
   logic [PTR_W-1:0]    tail_slot [NUM_QUEUES];
   logic [CNT_W-1:0]    fill_level [NUM_QUEUES];
   logic [CFG_W-1:0]    active_cfg;

   outcome_type expected_outcomes [$];
   int mismatches;
   int checked;
   int stuck_closes;

   // Append one id at the tail of a queue.
   function automatic void push_id(input int q, input logic [ID_WIDTH-1:0] v);
      slot_mem[q][tail_slot[q]] = v;
      tail_slot[q] = PTR_W'((int'(tail_slot[q]) + 1) % QUEUE_DEPTH);
      fill_level[q] = fill_level[q] + 1'b1;
   endfunction

   // Remove and return the id at the head of a queue.
   function automatic logic [ID_WIDTH-1:0] pop_id(input int q);
      logic [ID_WIDTH-1:0] v;
      v = slot_mem[q][head_slot[q]];
      head_slot[q] = PTR_W'((int'(head_slot[q]) + 1) % QUEUE_DEPTH);
      fill_level[q] = fill_level[q] - 1'b1;
      return v;
   endfunction

   // Apply one request to the mirror and return the result it must give.
   function automatic outcome_type apply_request(input logic [FUNC_W-1:0] op,
                                                 input logic [IDX_W-1:0] qi,
                                                 input logic [CID_W-1:0] cid);
      outcome_type o;
      int n;
      int q;
      int t;
      logic moved;
      logic stuck;
      o.status = STAT_INVALID;
      o.served = '0;
      o.empty = 1'b0;
      n = (int'(active_cfg) > NUM_QUEUES) ? NUM_QUEUES : int'(active_cfg);
      q = int'(qi);
      if (q < n) begin
         case (op)
            FUNC_ENQ: begin
               if (int'(fill_level[q]) >= QUEUE_DEPTH) begin
                  o.status = STAT_FULL;
               end else begin
                  push_id(q, cid[ID_WIDTH-1:0]);
                  o.status = STAT_OK;
               end
            end
            FUNC_CLOSE: begin
               // Deal the entries out one per pass to each other queue with room.
               if (n >= 2) begin
                  o.status = STAT_OK;
                  stuck = 1'b0;
                  while (fill_level[q] != 0 && !stuck) begin
                     moved = 1'b0;
                     for (t = 0; t < n; t++) begin
                        if (t != q && fill_level[q] != 0 &&
                            int'(fill_level[t]) < QUEUE_DEPTH) begin
                           push_id(t, pop_id(q));
                           moved = 1'b1;
                        end
                     end
                     if (!moved) begin
                        stuck = 1'b1;
                        o.status = STAT_FULL;
                        stuck_closes++;
                     end
                  end
               end
            end
            FUNC_SERVE: begin
               if (fill_level[q] == 0) begin
                  o.status = STAT_EMPTY;
               end else begin
                  o.served = CID_W'(pop_id(q));
                  o.status = STAT_OK;
               end
            end
            default: begin
            end
         endcase
         o.empty = (fill_level[q] == 0);
      end
      return o;
   endfunction

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Follow every transfer on the three ports at the clock edge that completes it.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_slot[q] = '0;
            tail_slot[q] = '0;
            fill_level[q] = '0;
         end
         active_cfg = ACTIVE_RESET;
         expected_outcomes.delete();
      end else begin
         // A result is compared with the oldest prediction.
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_status), -1);
            end else begin
               want = expected_outcomes.pop_front();
               checked++;
               if (rsp_status !== want.status) begin
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               end
               if (rsp_served_id !== want.served) begin
                  report_mismatch("served id", int'(rsp_served_id), int'(want.served));
               end
               if (rsp_queue_empty !== want.empty) begin
                  report_mismatch("queue empty", int'(rsp_queue_empty), int'(want.empty));
               end
            end
         end
         if (csr_wr_en) begin
            active_cfg = csr_wr_data;
         end
         if (start && !busy) begin
            expected_outcomes.push_back(apply_request(req_func, req_queue_index,
                                                      req_client_id));
         end
      end
      mismatch_count <= mismatches;
      open_count <= expected_outcomes.size();
      checked_count <= checked;
      stuck_close_count <= stuck_closes;
   end

endmodule

### bench/tb_multi_queue_drain_redistribute_top.sv
// Testbench top for the queue bank: clock, reset, stimulus, timeout and verdict.
module tb_multi_queue_drain_redistribute_top
   import mqdr_pkg::*;
;

   // Function code that the block does not define.
   localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int NUM_PHASES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [FUNC_W-1:0] req_func = '0;
   logic [IDX_W-1:0] req_queue_index = '0;
   logic [CID_W-1:0] req_client_id = '0;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   logic busy;
   logic rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [CID_W-1:0] rsp_served_id;
   logic rsp_queue_empty;

   int mismatch_count;
   int open_count;
   int checked_count;
   int stuck_close_count;
   int cycle_count = 0;

   int enq_sent = 0;
   int serve_sent = 0;
   int close_sent = 0;
   int undef_sent = 0;
   int settings_written = 0;
   int live_count = 8;

   // Register setting, enqueue share and length of each random phase.
   int phase_active [NUM_PHASES] = '{8, 2, 3, 1, 5, 8, 4, 0, 15, 6, 7, 8};
   int phase_enq [NUM_PHASES] = '{45, 75, 70, 50, 40, 65, 60, 50, 45, 30, 55, 45};
   int phase_len [NUM_PHASES] = '{150, 130, 130, 60, 130, 130, 130, 20, 120, 130, 130, 140};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_queue_drain_redistribute_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_queue_index (req_queue_index),
      .req_client_id   (req_client_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_served_id   (rsp_served_id),
      .rsp_queue_empty (rsp_queue_empty),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   mqdr_outcome_checker outcome_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_queue_index   (req_queue_index),
      .req_client_id     (req_client_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_served_id     (rsp_served_id),
      .rsp_queue_empty   (rsp_queue_empty),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .open_count        (open_count),
      .checked_count     (checked_count),
      .stuck_close_count (stuck_close_count)
   );

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, open_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one request after a random gap, hold it through the transfer and wait until the block is idle.
   task automatic issue(input logic [FUNC_W-1:0] op, input int qi, input int cid);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= op;
      req_queue_index <= IDX_W'(qi);
      req_client_id <= CID_W'(cid);
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op)
         FUNC_ENQ: enq_sent++;
         FUNC_SERVE: serve_sent++;
         FUNC_CLOSE: close_sent++;
         default: undef_sent++;
      endcase
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Write the active queue count while the block is idle.
   task automatic write_active(input int v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= CFG_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_count = (v > NUM_QUEUES) ? NUM_QUEUES : v;
      settings_written++;
   endtask

   // One random request; most indexes land on queues in use.
   task automatic random_request(input int enq_share);
      int r;
      int qi;
      logic [FUNC_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 2) begin
         op = FUNC_UNDEF;
      end else if (r < 10) begin
         op = FUNC_CLOSE;
      end else if (r < 10 + enq_share) begin
         op = FUNC_ENQ;
      end else begin
         op = FUNC_SERVE;
      end
      if (live_count > 0 && $urandom_range(0, 99) < 85) begin
         qi = $urandom_range(0, live_count - 1);
      end else begin
         qi = $urandom_range(0, 7);
      end
      issue(op, qi, $urandom_range(0, 65535));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part with all eight queues in use after reset.
      issue(FUNC_SERVE, 0, 16'h1111);
      issue(FUNC_ENQ, 0, 16'hFFFF);
      issue(FUNC_ENQ, 0, 16'h0000);
      issue(FUNC_ENQ, 7, 16'hA5A5);
      issue(FUNC_ENQ, 7, 16'h5A5A);
      issue(FUNC_SERVE, 0, 16'h0000);
      issue(FUNC_UNDEF, 0, 16'h0000);
      issue(FUNC_UNDEF, 7, 16'hFFFF);
      issue(FUNC_CLOSE, 0, 16'h0000);
      issue(FUNC_CLOSE, 7, 16'h0000);
      issue(FUNC_SERVE, 1, 16'h0000);
      issue(FUNC_SERVE, 1, 16'h0000);
      issue(FUNC_SERVE, 0, 16'h0000);
      issue(FUNC_SERVE, 0, 16'h0000);

      // A single queue in use: closes are refused, higher indexes are invalid.
      write_active(1);
      issue(FUNC_CLOSE, 0, 16'h0000);
      issue(FUNC_ENQ, 0, 16'h1234);
      issue(FUNC_ENQ, 1, 16'h4321);
      issue(FUNC_CLOSE, 0, 16'h0000);

      // No queue in use: everything is invalid.
      write_active(0);
      issue(FUNC_SERVE, 0, 16'h0000);
      issue(FUNC_ENQ, 0, 16'h7FFF);

      // A count above the bank size behaves as the full bank.
      write_active(15);
      issue(FUNC_ENQ, 7, 16'h8001);
      issue(FUNC_SERVE, 7, 16'h0000);

      // Random phases over several register settings and operation mixes.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_active(phase_active[p]);
         for (int k = 0; k < phase_len[p]; k++) begin
            if ($urandom_range(0, 99) < 2) begin
               wait_idle();
            end
            random_request(phase_enq[p]);
         end
      end

      // Let the last results come back, then give the verdict.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests (%0d enqueue, %0d serve, %0d close, %0d undefined) over %0d register writes.",
               enq_sent + serve_sent + close_sent + undef_sent, enq_sent, serve_sent,
               close_sent, undef_sent, settings_written);
      $display("%0d results checked; %0d closes stopped on full targets.",
               checked_count, stuck_close_count);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
